// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define LBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen outside reset.
`define LBS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== sv/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer package
// Command and mode codes, item field widths and shared helpers.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BITS_W  = 2;

  localparam logic [CNT_W-1:0] FOREVER     = 8'd255;
  localparam logic [LEN_W-1:0] MIN_PATTERN = 8'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 3'd0,
    REQ_ON    = 3'd1,
    REQ_OFF   = 3'd2,
    REQ_BLINK = 3'd3,
    REQ_WORD  = 3'd4,
    REQ_START = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    MODE_ON        = 3'd0,
    MODE_OFF       = 3'd1,
    MODE_BLINK_ON  = 3'd2,
    MODE_BLINK_OFF = 3'd3,
    MODE_PATTERN   = 3'd4
  } mode_e;

  typedef logic [BITS_W-1:0] led_bits_t;

  typedef struct packed {
    led_bits_t led_levels;
    led_bits_t timers_running;
    logic      rejected;
  } rsp_item_t;

  // Clamp a millisecond value to 16 bits.
  function automatic logic [WORD_W-1:0] sat16(input logic [TIME_W-1:0] v);
    return (|v[TIME_W-1:WORD_W]) ? {WORD_W{1'b1}} : v[WORD_W-1:0];
  endfunction

endpackage

// ===== sv/lbs_req_if.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface lbs_req_if;
  logic                              valid;
  logic                              ready;
  logic [lbs_pkg::REQ_W-1:0]         req_type;
  logic [lbs_pkg::IDX_W-1:0]         led_index;
  logic [lbs_pkg::TIME_W-1:0]        time_ms;
  logic [lbs_pkg::CNT_W-1:0]         repeat_count;
  logic [lbs_pkg::SLOT_W-1:0]        pattern_slot;
  logic [lbs_pkg::LEN_W-1:0]         pattern_length;

  modport source (
    output valid, req_type, led_index, time_ms, repeat_count, pattern_slot,
           pattern_length,
    input  ready
  );
  modport sink (
    input  valid, req_type, led_index, time_ms, repeat_count, pattern_slot,
           pattern_length,
    output ready
  );
endinterface

// ===== sv/lbs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer status channel
// Valid/ready channel carrying one status item per command.
// ----------------------------------------------------------------------------
interface lbs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [lbs_pkg::BITS_W-1:0] led_levels;
  logic [lbs_pkg::BITS_W-1:0] timers_running;
  logic                       rejected;

  modport source (output valid, led_levels, timers_running, rejected, input ready);
  modport sink   (input valid, led_levels, timers_running, rejected, output ready);
endinterface

// ===== sv/led_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED blink sequencer
// Per-LED on/off timeouts, counted blinking and stored duration patterns.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------------------
//   req_i   | in  | valid / ready | req_type, led_index, time_ms,
//           |     |               | repeat_count, pattern_slot, pattern_length
//   rsp_o   | out | valid / ready | led_levels, timers_running, rejected
//
// One command item per cycle while req_i.ready is high. Each item is resolved
// in the cycle it is accepted; its status item sits in a two-entry output
// queue and is shown on rsp_o from there. req_i.ready drops only while both
// queue entries wait. The pattern store is a synchronous RAM read ahead, at
// each LED's next pattern position, with same-cycle write forwarding; per-entry
// valid bits make every entry read as zero after reset, so no clearing pass.
// ----------------------------------------------------------------------------
module led_blink_sequencer #(
  parameter int unsigned LED_COUNT     = 2,
  parameter int unsigned PATTERN_DEPTH = 20
) (
  input logic         clk_i,
  input logic         rst_ni,
  lbs_req_if.sink     req_i,
  lbs_rsp_if.source   rsp_o
);

  `include "assert_macros.svh"

  localparam int unsigned MemDepth = LED_COUNT * PATTERN_DEPTH;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned PosW     = $clog2(PATTERN_DEPTH + 1);
  localparam int unsigned LedW     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned WordW    = lbs_pkg::WORD_W;
  localparam int unsigned TimeW    = lbs_pkg::TIME_W;
  localparam int unsigned CntW     = lbs_pkg::CNT_W;

  // --------------------------------------------------------------------------
  // Per-LED state (one lane per LED)
  // --------------------------------------------------------------------------
  logic [LED_COUNT-1:0]                 level_q, level_d;
  lbs_pkg::mode_e [LED_COUNT-1:0]       mode_q, mode_d;
  logic [LED_COUNT-1:0][CntW-1:0]       rep_q, rep_d;
  logic [LED_COUNT-1:0][WordW-1:0]      hp_q, hp_d;
  logic [LED_COUNT-1:0][PosW-1:0]       used_q, used_d;
  logic [LED_COUNT-1:0][PosW-1:0]       pos_q, pos_d;
  logic [LED_COUNT-1:0][TimeW-1:0]      tl_q, tl_d;
  logic [LED_COUNT-1:0]                 on_q, on_d;
  // Shadow of pattern word 0 per LED, needed the cycle a pattern starts.
  logic [LED_COUNT-1:0][WordW-1:0]      w0_q, w0_d;

  // --------------------------------------------------------------------------
  // Pattern store
  // --------------------------------------------------------------------------
  logic [WordW-1:0]      mem [MemDepth];
  logic [MemDepth-1:0]   vld_q;
  logic [WordW-1:0]      rd_q [LED_COUNT];
  logic [LED_COUNT-1:0]  rdv_q;
  logic [AddrW-1:0]      rd_addr [LED_COUNT];
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [WordW-1:0]      wr_data;

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  logic                  in_fire;
  logic                  out_fire;
  logic                  in_ready;
  logic                  rej;
  logic                  led_bad;
  logic                  slot_bad;
  logic                  is_tick;
  logic                  cmd_ok;
  logic [LedW-1:0]       led_sel;
  logic [WordW-1:0]      tms_sat;
  logic [PosW-1:0]       len_clip;
  lbs_pkg::req_e         req;

  assign req      = lbs_pkg::req_e'(req_i.req_type);
  assign in_fire  = req_i.valid && in_ready;
  assign out_fire = rsp_o.valid && rsp_o.ready;
  assign led_sel  = LedW'(req_i.led_index);
  assign led_bad  = 32'(req_i.led_index) >= LED_COUNT;
  assign slot_bad = 32'(req_i.pattern_slot) >= PATTERN_DEPTH;
  assign is_tick  = (req == lbs_pkg::REQ_TICK);
  assign tms_sat  = lbs_pkg::sat16(req_i.time_ms);
  assign len_clip = (32'(req_i.pattern_length) > PATTERN_DEPTH) ?
                    PosW'(PATTERN_DEPTH) : PosW'(req_i.pattern_length);

  always_comb begin
    unique case (req)
      lbs_pkg::REQ_TICK:  rej = 1'b0;
      lbs_pkg::REQ_ON,
      lbs_pkg::REQ_OFF,
      lbs_pkg::REQ_BLINK: rej = led_bad;
      lbs_pkg::REQ_WORD:  rej = led_bad || slot_bad;
      lbs_pkg::REQ_START: rej = led_bad || (req_i.pattern_length < lbs_pkg::MIN_PATTERN);
      default:            rej = 1'b1;  // undefined request codes
    endcase
  end

  assign cmd_ok  = in_fire && !is_tick && !rej;
  assign wr_en   = cmd_ok && (req == lbs_pkg::REQ_WORD);
  assign wr_addr = AddrW'(32'(led_sel) * PATTERN_DEPTH + 32'(req_i.pattern_slot));
  assign wr_data = tms_sat;

  // --------------------------------------------------------------------------
  // Next state: tick runs every LED's timer, commands hit one LED
  // --------------------------------------------------------------------------
  always_comb begin
    logic [WordW-1:0] nxt_word;
    logic [PosW-1:0]  pos_inc;
    level_d = level_q;
    mode_d  = mode_q;
    rep_d   = rep_q;
    hp_d    = hp_q;
    used_d  = used_q;
    pos_d   = pos_q;
    tl_d    = tl_q;
    on_d    = on_q;
    w0_d    = w0_q;
    for (int i = 0; i < LED_COUNT; i++) begin
      // Word at this LED's current pattern position (zero if never written).
      nxt_word = rdv_q[i] ? rd_q[i] : '0;
      pos_inc  = pos_q[i] + PosW'(1);
      if (in_fire && is_tick) begin
        if (on_q[i]) begin
          if (tl_q[i] <= TimeW'(1)) begin
            tl_d[i] = '0;
            on_d[i] = 1'b0;
            unique case (mode_q[i])
              lbs_pkg::MODE_ON:  level_d[i] = 1'b0;
              lbs_pkg::MODE_OFF: level_d[i] = 1'b1;
              lbs_pkg::MODE_BLINK_ON: begin
                level_d[i] = 1'b0;
                if (rep_q[i] == CntW'(1)) begin
                  // last counted blink done
                  rep_d[i]  = '0;
                  mode_d[i] = lbs_pkg::MODE_OFF;
                end else begin
                  if (rep_q[i] != '0 && rep_q[i] != lbs_pkg::FOREVER) begin
                    rep_d[i] = rep_q[i] - CntW'(1);
                  end
                  mode_d[i] = lbs_pkg::MODE_BLINK_OFF;
                  tl_d[i]   = TimeW'(hp_q[i]);
                  on_d[i]   = 1'b1;
                end
              end
              lbs_pkg::MODE_BLINK_OFF: begin
                level_d[i] = 1'b1;
                mode_d[i]  = lbs_pkg::MODE_BLINK_ON;
                tl_d[i]    = TimeW'(hp_q[i]);
                on_d[i]    = 1'b1;
              end
              lbs_pkg::MODE_PATTERN: begin
                if (rep_q[i] == '0) begin
                  level_d[i] = 1'b0;
                  mode_d[i]  = lbs_pkg::MODE_OFF;
                end else begin
                  level_d[i] = ~pos_q[i][0];  // lit on even positions
                  tl_d[i]    = TimeW'(nxt_word);
                  on_d[i]    = 1'b1;
                  if (pos_inc >= used_q[i]) begin
                    pos_d[i] = '0;
                    if (rep_q[i] != lbs_pkg::FOREVER) begin
                      rep_d[i] = rep_q[i] - CntW'(1);
                    end
                  end else begin
                    pos_d[i] = pos_inc;
                  end
                end
              end
              default: ;
            endcase
          end else begin
            tl_d[i] = tl_q[i] - TimeW'(1);
          end
        end
      end else if (cmd_ok && (led_sel == LedW'(i))) begin
        unique case (req)
          lbs_pkg::REQ_ON, lbs_pkg::REQ_OFF: begin
            level_d[i] = (req == lbs_pkg::REQ_ON);
            mode_d[i]  = (req == lbs_pkg::REQ_ON) ? lbs_pkg::MODE_ON : lbs_pkg::MODE_OFF;
            tl_d[i]    = req_i.time_ms;
            on_d[i]    = (req_i.time_ms != '0);
          end
          lbs_pkg::REQ_BLINK: begin
            hp_d[i]    = tms_sat;
            level_d[i] = 1'b0;
            mode_d[i]  = lbs_pkg::MODE_BLINK_OFF;
            tl_d[i]    = TimeW'(tms_sat);
            on_d[i]    = 1'b1;
            rep_d[i]   = req_i.repeat_count;
          end
          lbs_pkg::REQ_WORD: begin
            if (req_i.pattern_slot == '0) begin
              w0_d[i] = tms_sat;
            end
          end
          lbs_pkg::REQ_START: begin
            level_d[i] = 1'b1;
            mode_d[i]  = lbs_pkg::MODE_PATTERN;
            used_d[i]  = len_clip;
            rep_d[i]   = req_i.repeat_count;
            tl_d[i]    = TimeW'(w0_q[i]);
            on_d[i]    = 1'b1;
            pos_d[i]   = PosW'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        mode_q[i] <= lbs_pkg::MODE_OFF;
      end
      rep_q   <= '0;
      hp_q    <= '0;
      used_q  <= '0;
      pos_q   <= '0;
      tl_q    <= '0;
      on_q    <= '0;
      w0_q    <= '0;
    end else begin
      level_q <= level_d;
      mode_q  <= mode_d;
      rep_q   <= rep_d;
      hp_q    <= hp_d;
      used_q  <= used_d;
      pos_q   <= pos_d;
      tl_q    <= tl_d;
      on_q    <= on_d;
      w0_q    <= w0_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pattern RAM: read at next position, forward a same-cycle write
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      rd_addr[i] = (32'(pos_d[i]) >= PATTERN_DEPTH) ? AddrW'(i * PATTERN_DEPTH) :
                   AddrW'(i * PATTERN_DEPTH + 32'(pos_d[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    for (int i = 0; i < LED_COUNT; i++) begin
      rd_q[i] <= (wr_en && (wr_addr == rd_addr[i])) ? wr_data : mem[rd_addr[i]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rdv_q <= '0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      for (int i = 0; i < LED_COUNT; i++) begin
        rdv_q[i] <= vld_q[rd_addr[i]] || (wr_en && (wr_addr == rd_addr[i]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry status queue
  // --------------------------------------------------------------------------
  lbs_pkg::rsp_item_t res_d;
  lbs_pkg::rsp_item_t buf_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;

  assign res_d.led_levels     = lbs_pkg::led_bits_t'(level_d);
  assign res_d.timers_running = lbs_pkg::led_bits_t'(on_d);
  assign res_d.rejected       = rej;

  assign in_ready             = (cnt_q != 2'd2);
  assign req_i.ready          = in_ready;
  assign rsp_o.valid          = (cnt_q != 2'd0);
  assign rsp_o.led_levels     = buf_q[rp_q].led_levels;
  assign rsp_o.timers_running = buf_q[rp_q].timers_running;
  assign rsp_o.rejected       = buf_q[rp_q].rejected;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_q[wp_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_q ^ in_fire;
      rp_q <= rp_q ^ out_fire;
      case ({in_fire, out_fire})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < LED_COUNT; g++) begin : g_chk
    `LBS_ASSERT(a_pos_range, (mode_q[g] == lbs_pkg::MODE_PATTERN) |-> (pos_q[g] < used_q[g]), "pattern position past used length")
    `LBS_ASSERT_NEVER(a_idle_timer, !on_q[g] && (tl_q[g] != '0), "stopped timer holds a count")
  end
  `LBS_ASSERT(a_rej_hold, (in_fire && rej) |=> ($stable(level_q) && $stable(on_q)), "rejected command changed LED state")
  `LBS_ASSERT(a_queue_fill, (in_fire && !out_fire) |=> (cnt_q == $past(cnt_q) + 2'd1), "status queue count slipped")

endmodule
